@@ src/fcma_pkg.sv @@
// fcma_pkg: shared constants and controller/datapath command types for the
// four-channel moving average. No dependencies; imported by all but fcma_ram.
`default_nettype none

package fcma_pkg;

   // channel count and lane index width
   localparam int NUM_CH = 4;
   localparam int CH_W   = 2;

   // defaults handed down from the top level
   localparam int MAX_WINDOW_DEF  = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // window_len register
   localparam int WIN_FIELD_W = 7;
   localparam int WIN_RESET   = 8;

   // register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_WINDOW_LEN = 1'b0;

   // controller to datapath
   typedef struct packed {
      logic            latch;     // take the input beat, issue the store read
      logic            upd;       // update sums, write the store, set divisor
      logic            div_load;  // load |sum| of channel ch into the divider
      logic            div_step;  // two quotient bits
      logic            div_last;  // final step: write signed quotient to lane ch
      logic            out_load;  // move results into the output register
      logic [CH_W-1:0] ch;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic win_zero;             // window of zero: samples pass straight through
   } stat_type;

endpackage

`default_nettype wire

@@ src/fcma_ram.sv @@
// fcma_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fcma_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/fcma_ctrl.sv @@
// fcma_ctrl: sequencer for the moving average; handshakes and divider stepping.
// Depends on fcma_pkg.
`default_nettype none

module fcma_ctrl #(
   parameter int SAMPLE_BITS = fcma_pkg::SAMPLE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fcma_pkg::stat_type stat,
   output fcma_pkg::cmd_type       cmd,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready
);
   import fcma_pkg::*;

   // quotient bits rounded up to an even count, two per step
   localparam int Q_W   = 2 * ((SAMPLE_BITS + 1) / 2);
   localparam int STEPS = Q_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UPD  = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_RUN  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic            rvalid_ff, rvalid_in;

   // next state and commands
   always_comb begin
      cmd      = '0;
      cmd.ch   = ch_ff;
      state_in = state_ff;
      ch_in    = ch_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = stat.win_zero ? ST_DONE : ST_UPD;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            ch_in    = '0;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = ST_RUN;
         end
         ST_RUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               cmd.div_last = 1'b1;
               if (ch_ff == CH_W'(NUM_CH - 1)) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!rvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output beat valid
   always_comb begin
      if (cmd.out_load) begin
         rvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ch_ff     <= '0;
         cnt_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ch_ff     <= ch_in;
         cnt_ff    <= cnt_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rvalid_ff;

endmodule

`default_nettype wire

@@ src/fcma_dpath.sv @@
// fcma_dpath: sample store, running sums, fill/slot counters, window register,
// shared radix-4 divider and output register. Depends on fcma_pkg, fcma_ram.
`default_nettype none

module fcma_dpath #(
   parameter int MAX_WINDOW  = fcma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = fcma_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_W = ((fcma_pkg::NUM_CH * SAMPLE_BITS + 7) / 8) * 8,
   localparam int N_W    = $clog2(MAX_WINDOW + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire fcma_pkg::cmd_type                cmd,
   output fcma_pkg::stat_type                    stat,
   input  wire logic [DATA_W-1:0]                req_tdata,
   output logic      [DATA_W-1:0]                rsp_tdata,
   input  wire logic                             cfg_wr,
   input  wire logic [fcma_pkg::WIN_FIELD_W-1:0] cfg_wdata,
   output logic      [N_W-1:0]                   win_len
);
   import fcma_pkg::*;

   localparam int A_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int Q_W   = 2 * ((SAMPLE_BITS + 1) / 2);
   localparam int R_W   = N_W + Q_W;
   localparam int ROW_W = NUM_CH * SAMPLE_BITS;

   // window value saturated to the store depth
   function automatic logic [N_W-1:0] clamp_win(input logic [WIN_FIELD_W-1:0] v);
      if (int'(v) > MAX_WINDOW) begin
         clamp_win = N_W'(MAX_WINDOW);
      end else begin
         clamp_win = N_W'(v);
      end
   endfunction

   // one restoring division step: acc = {remainder, dividend/quotient bits}
   function automatic logic [R_W-1:0] div_bit(input logic [R_W-1:0] acc,
                                              input logic [N_W-1:0] d);
      logic [N_W:0] trial;
      logic [N_W:0] diff;
      trial = acc[R_W-1:Q_W-1];
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         div_bit = {diff[N_W-1:0], acc[Q_W-2:0], 1'b1};
      end else begin
         div_bit = {trial[N_W-1:0], acc[Q_W-2:0], 1'b0};
      end
   endfunction

   logic [N_W-1:0]   win_ff, win_in;
   logic [N_W-1:0]   fill_ff, fill_in;
   logic [A_W-1:0]   wslot_ff, wslot_in;
   logic [A_W-1:0]   slot_ff;
   logic             warm_ff;
   logic [N_W-1:0]   n_ff;
   logic [R_W-1:0]   div_ff;
   logic             neg_ff;
   logic [DATA_W-1:0] out_ff;

   logic signed [SAMPLE_BITS-1:0] samp_ff [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] res_ff  [NUM_CH];
   logic signed [SUM_W-1:0]       sum_ff  [NUM_CH];
   logic signed [SUM_W-1:0]       sum_in  [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] old_lane [NUM_CH];

   logic             warming;
   logic [A_W-1:0]   slot;
   logic [ROW_W-1:0] rd_row;
   logic [ROW_W-1:0] wr_row;
   logic [DATA_W-1:0] res_pk;
   logic signed [SUM_W-1:0] div_sum;
   logic [SUM_W-1:0] div_mag;
   logic [R_W-1:0]   div_nx;
   logic [SAMPLE_BITS-1:0] quo;

   // slot choice: fill in order while warming, else overwrite the oldest
   assign warming = (fill_ff < win_ff);
   assign slot    = warming ? fill_ff[A_W-1:0] : wslot_ff;

   fcma_ram #(
      .WIDTH (ROW_W),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.upd),
      .wr_addr (slot_ff),
      .wr_data (wr_row),
      .rd_en   (cmd.latch),
      .rd_addr (slot),
      .rd_data (rd_row)
   );

   // sum update; an entry not yet written since the last clear reads as zero
   always_comb begin
      wr_row = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         wr_row[c*SAMPLE_BITS +: SAMPLE_BITS] = samp_ff[c];
         old_lane[c] = warm_ff ? '0 : rd_row[c*SAMPLE_BITS +: SAMPLE_BITS];
         sum_in[c]   = sum_ff[c] - SUM_W'(old_lane[c]) + SUM_W'(samp_ff[c]);
      end
   end

   // window, fill count and write slot
   always_comb begin
      win_in   = win_ff;
      fill_in  = fill_ff;
      wslot_in = wslot_ff;
      if (cfg_wr) begin
         win_in   = clamp_win(cfg_wdata);
         fill_in  = '0;
         wslot_in = '0;
      end else if (cmd.upd) begin
         if (warm_ff) begin
            fill_in = fill_ff + 1'b1;
         end else if ((N_W'(wslot_ff) + 1'b1) >= win_ff) begin
            wslot_in = '0;
         end else begin
            wslot_in = wslot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= clamp_win(WIN_FIELD_W'(WIN_RESET));
         fill_ff  <= '0;
         wslot_ff <= '0;
      end else begin
         win_ff   <= win_in;
         fill_ff  <= fill_in;
         wslot_ff <= wslot_in;
      end
   end

   // running sums
   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CH; c++) begin
         if (reset || cfg_wr) begin
            sum_ff[c] <= '0;
         end else if (cmd.upd) begin
            sum_ff[c] <= sum_in[c];
         end
      end
   end

   // input beat capture and divisor
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         warm_ff <= warming;
         slot_ff <= slot;
         for (int c = 0; c < NUM_CH; c++) begin
            samp_ff[c] <= req_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
         end
      end
      if (cmd.upd) begin
         n_ff <= warm_ff ? (fill_ff + 1'b1) : win_ff;
      end
   end

   // shared divider: magnitude in, two quotient bits a cycle
   assign div_sum = sum_ff[cmd.ch];
   assign div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
   assign div_nx  = div_bit(div_bit(div_ff, n_ff), n_ff);
   assign quo     = div_nx[SAMPLE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_ff <= R_W'(div_mag);
         neg_ff <= div_sum[SUM_W-1];
      end else if (cmd.div_step) begin
         div_ff <= div_nx;
      end
   end

   // result lanes: pass-through samples or signed truncated quotients
   always_ff @(posedge clock) begin
      if (cmd.latch && stat.win_zero) begin
         for (int c = 0; c < NUM_CH; c++) begin
            res_ff[c] <= req_tdata[c*SAMPLE_BITS +: SAMPLE_BITS];
         end
      end else if (cmd.div_last) begin
         res_ff[cmd.ch] <= neg_ff ? -quo : quo;
      end
   end

   always_comb begin
      res_pk = '0;
      for (int c = 0; c < NUM_CH; c++) begin
         res_pk[c*SAMPLE_BITS +: SAMPLE_BITS] = res_ff[c];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= res_pk;
      end
   end

   assign stat.win_zero = (win_ff == '0);
   assign rsp_tdata     = out_ff;
   assign win_len       = win_ff;

endmodule

`default_nettype wire

@@ src/four_channel_moving_average.sv @@
// Channel | Dir | Beat
// req     | in  | tdata: pos_x_sample, pos_y_sample, angle_x_sample, temp_sample
// rsp     | out | tdata: pos_x_mean, pos_y_mean, angle_x_mean, temp_mean
// csr     | in  | APB, register 0 at byte 0: window_len
//
// One record is processed at a time; the single radix-4 serial divider, shared
// by the four channels, works through them in turn and sets the record rate.
// With window_len zero a record passes straight through, bypassing the divider.
// Reset is synchronous; sums and counters clear at once, the store needs no
// clearing pass as unwritten slots read as zero. A stalled rsp beat holds
// in its output register; the next record is taken while it waits.
// Depends on fcma_pkg, fcma_ctrl, fcma_dpath, fcma_ram.
`default_nettype none

module four_channel_moving_average #(
   parameter int MAX_WINDOW  = fcma_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS = fcma_pkg::SAMPLE_BITS_DEF,
   localparam int DATA_W = ((fcma_pkg::NUM_CH * SAMPLE_BITS + 7) / 8) * 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // pos_x_sample, pos_y_sample, angle_x_sample, temp_sample (low to high)
   input  wire logic [DATA_W-1:0]               req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pos_x_mean, pos_y_mean, angle_x_mean, temp_mean (low to high)
   output logic      [DATA_W-1:0]               rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fcma_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [fcma_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [fcma_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import fcma_pkg::*;

   localparam int N_W = $clog2(MAX_WINDOW + 1);

   cmd_type        cmd;
   stat_type       stat;
   logic           cfg_wr;
   logic           reg_sel;
   logic [N_W-1:0] win_len;

   // register decode
   assign csr_pready = 1'b1;
   assign reg_sel    = (csr_paddr[CSR_ADDR_W-1] == REG_WINDOW_LEN);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? CSR_DATA_W'(win_len) : '0;

   fcma_ctrl #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .stat       (stat),
      .cmd        (cmd),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   fcma_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cfg_wr    (cfg_wr),
      .cfg_wdata (csr_pwdata[WIN_FIELD_W-1:0]),
      .win_len   (win_len)
   );

`ifndef SYNTH
   // one record in flight: no second beat right after an accepted one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input beat accepted while a record is in flight");

   // results never overwrite an output beat that has not been taken
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid || rsp_tready))
      else $error("output register overwritten while stalled");

   // sequencer issues at most one datapath operation a cycle
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.latch, cmd.upd, cmd.div_load, cmd.div_step, cmd.out_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

@@ dv/fcma_mean_check.sv @@
// fcma_mean_check: watches the record, result and register ports of the moving
// average, predicts every result beat and compares it channel by channel.
// Depends on fcma_pkg only; instantiated beside u_dut by the test top.
module fcma_mean_check (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // pos_x_sample, pos_y_sample, angle_x_sample, temp_sample (low to high)
   input  wire logic [63:0]                     req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // pos_x_mean, pos_y_mean, angle_x_mean, temp_mean (low to high)
   input  wire logic [63:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fcma_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [fcma_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic                            csr_pready,
   output int                                   failures,
   output int                                   outstanding
);
   import fcma_pkg::*;

   localparam int SW = SAMPLE_BITS_DEF;
   localparam int DW = NUM_CH * SW;
   localparam logic [CSR_ADDR_W-1:0] WIN_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_LEN);

   string chan_name [NUM_CH] = '{"pos_x", "pos_y", "angle_x", "temp"};

   // predictor state: window, fill level, oldest slot, history and sums
   int unsigned   win_len;
   int unsigned   fill_count;
   int unsigned   oldest_slot;
   int            sample_hist [NUM_CH][MAX_WINDOW_DEF];
   longint        window_sum [NUM_CH];
   logic [DW-1:0] expected_means [$];
   int            fail_count = 0;

   function automatic int unsigned clamp_window(input logic [WIN_FIELD_W-1:0] v);
      return (v > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(v);
   endfunction

   function automatic void clear_history();
      for (int ch = 0; ch < NUM_CH; ch++) begin
         for (int s = 0; s < MAX_WINDOW_DEF; s++) sample_hist[ch][s] = 0;
         window_sum[ch] = 0;
      end
      fill_count  = 0;
      oldest_slot = 0;
   endfunction

   // one record in, the four truncated window means out
   function automatic logic [DW-1:0] predict_means(input logic [DW-1:0] beat);
      logic [DW-1:0]        means;
      logic signed [SW-1:0] s;
      int unsigned          slot;
      int unsigned          n;
      bit                   warming;
      means = beat;
      // zero window: straight through, history untouched
      if (win_len == 0) return means;
      warming = fill_count < win_len;
      slot    = warming ? fill_count : oldest_slot;
      n       = warming ? fill_count + 1 : win_len;
      for (int ch = 0; ch < NUM_CH; ch++) begin
         s = beat[ch*SW +: SW];
         window_sum[ch] -= sample_hist[ch][slot];
         sample_hist[ch][slot] = s;
         window_sum[ch] += s;
         // signed division truncates toward zero
         means[ch*SW +: SW] = SW'(window_sum[ch] / longint'(n));
      end
      if (warming) begin
         fill_count++;
      end else begin
         oldest_slot++;
         if (oldest_slot >= win_len) oldest_slot = 0;
      end
      return means;
   endfunction

   always @(posedge clock) begin
      logic [DW-1:0] want;
      if (reset) begin
         win_len = WIN_RESET;
         clear_history();
         expected_means.delete();
      end else begin
         // window write: saturate and drop all history
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == WIN_ADDR) begin
            win_len = clamp_window(csr_pwdata[WIN_FIELD_W-1:0]);
            clear_history();
         end
         // result beat against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               $display("%0t: result beat %h with nothing expected", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_means.pop_front();
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  if (want[ch*SW +: SW] !== rsp_tdata[ch*SW +: SW]) begin
                     $display("%0t: %s_mean expected %0d, got %0d", $time, chan_name[ch],
                              $signed(want[ch*SW +: SW]), $signed(rsp_tdata[ch*SW +: SW]));
                     fail_count++;
                  end
               end
            end
         end
         // accepted record beat
         if (req_tvalid && req_tready) expected_means.push_back(predict_means(req_tdata));
      end
      failures    <= fail_count;
      outstanding <= expected_means.size();
   end

endmodule

@@ dv/four_channel_moving_average_test.sv @@
// four_channel_moving_average_test: drives records, window writes and random
// back-pressure into the moving average and gives the verdict.
// Depends on fcma_pkg, four_channel_moving_average and fcma_mean_check.
module four_channel_moving_average_test;
   import fcma_pkg::*;

   localparam int SW           = SAMPLE_BITS_DEF;
   localparam int DW           = NUM_CH * SW;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam logic [CSR_ADDR_W-1:0] WIN_ADDR = CSR_ADDR_W'(4 * REG_WINDOW_LEN);
   localparam logic [SW-1:0] S_MIN = 16'h8000;
   localparam logic [SW-1:0] S_MAX = 16'h7FFF;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // pos_x_sample, pos_y_sample, angle_x_sample, temp_sample (low to high)
   logic [DW-1:0]         req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // pos_x_mean, pos_y_mean, angle_x_mean, temp_mean (low to high)
   logic [DW-1:0]         rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int cycle = 0;
   bit calm  = 1'b0;

   // window per phase; the last entry is replaced by a random one
   int win_plan [10] = '{1, 64, 0, 127, 3, 65, 2, 40, 0, 0};

   always #6 clock = ~clock;

   four_channel_moving_average u_dut (.*);

   fcma_mean_check u_check (.*);

   // result back-pressure and run limit
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99, 0) >= 12);
      cycle <= cycle + 1;
      if (cycle >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [DW-1:0] pack_record(input logic [SW-1:0] px, py, ax, tp);
      return {tp, ax, py, px};
   endfunction

   // extremes, small values round zero, otherwise anything
   function automatic logic [SW-1:0] draw_sample();
      case ($urandom_range(7, 0))
         0: return S_MIN;
         1: return S_MAX;
         2: return SW'($urandom_range(8, 0) - 4);
         default: return SW'($urandom);
      endcase
   endfunction

   // present one record beat, with an occasional gap before it
   task automatic send_record(input logic [DW-1:0] rec);
      if (!calm && $urandom_range(99, 0) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rec;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // APB write of the window, junk above the field
   task automatic write_window(input logic [WIN_FIELD_W-1:0] w);
      logic [CSR_DATA_W-1:0] data;
      data = $urandom;
      data[WIN_FIELD_W-1:0] = w;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WIN_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      logic [WIN_FIELD_W-1:0] w;
      int                     count;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed records at the reset window of eight
      send_record(pack_record(16'h0000, 16'h0000, 16'h0000, 16'h0000));
      send_record(pack_record(S_MAX, S_MAX, S_MAX, S_MAX));
      send_record(pack_record(S_MIN, S_MIN, S_MIN, S_MIN));
      send_record(pack_record(S_MIN, S_MAX, 16'h0001, 16'hFFFF));
      send_record(pack_record(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555));
      // negative means truncate toward zero
      send_record(pack_record(16'hFFFD, 16'hFFFF, 16'h0003, 16'hFFFE));
      // fill past the window so the oldest entries wrap out
      repeat (8) send_record(pack_record(S_MAX, S_MIN, S_MAX, S_MIN));
      repeat (4) send_record(pack_record(S_MIN, S_MAX, S_MIN, S_MAX));
      send_record(pack_record(16'hFFFF, 16'h0001, 16'h8001, 16'h7FFE));
      drain_results();

      // random phases, one window each, written while idle
      for (int p = 0; p < 10; p++) begin
         w = (p == 9) ? WIN_FIELD_W'($urandom_range(127, 0)) : WIN_FIELD_W'(win_plan[p]);
         write_window(w);
         calm  = (p == 3);
         count = (w >= 32) ? 140 : 40;
         for (int i = 0; i < count; i++) begin
            // a full window of one extreme pushes the sums to their limits
            if (p == 1 && i < 64)
               send_record(pack_record(S_MIN, S_MIN, S_MIN, S_MIN));
            else if (p == 3 && i < 64)
               send_record(pack_record(S_MAX, S_MAX, S_MAX, S_MAX));
            else
               send_record(pack_record(draw_sample(), draw_sample(), draw_sample(),
                                       draw_sample()));
         end
         drain_results();
      end
      calm = 1'b0;

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
src/fcma_pkg.sv
src/fcma_ram.sv
src/fcma_ctrl.sv
src/fcma_dpath.sv
src/four_channel_moving_average.sv
dv/fcma_mean_check.sv
dv/four_channel_moving_average_test.sv
